// ----- hw/rtl/sdtr_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtr_pkg
// Shared types and constants for the scope decimate / trigger / render core:
// request and result words, config register indexes and reset values.
// ----------------------------------------------------------------------------
package sdtr_pkg;

    // one request word: sample or render request
    typedef struct packed {
        logic               req_type;
        logic signed [15:0] sample;
    } t_req_word;

    // one result word: a screen point
    typedef struct packed {
        logic [5:0]         column;
        logic signed [15:0] y_coord;
        logic               last;
    } t_res_word;

    // request kinds
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // config port
    localparam int CFG_DATA_W = 16;
    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SPP    = 3'd0;
    localparam t_cfg_idx CFG_ZOOM   = 3'd1;
    localparam t_cfg_idx CFG_TRIG   = 3'd2;
    localparam t_cfg_idx CFG_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_HEIGHT = 3'd4;
    localparam t_cfg_idx CFG_PHASE  = 3'd5;
    localparam t_cfg_idx CFG_BLOCK  = 3'd6;

    // trigger modes, anything else runs free
    localparam logic [1:0] TRIG_RISE  = 2'd0;
    localparam logic [1:0] TRIG_PHASE = 2'd1;

    // register reset values
    localparam logic [11:0] RST_SPP    = 12'd64;
    localparam logic [15:0] RST_ZOOM   = 16'd4096;
    localparam logic [1:0]  RST_TRIG   = 2'd0;
    localparam logic [6:0]  RST_WIDTH  = 7'd64;
    localparam logic [11:0] RST_HEIGHT = 12'd256;
    localparam logic [15:0] RST_PHASE  = 16'd0;
    localparam logic [15:0] RST_BLOCK  = 16'd512;

    // sample limits, Q1.15
    localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [15:0] Y_MAX      = 16'sh7fff;
    localparam logic signed [15:0] Y_MIN      = 16'sh8000;

endpackage

// ----- hw/rtl/scope_decimate_trigger_render_core.sv -----
// Sample words: one per cycle while idle, taken in the cycle they arrive, busy
//   stays low. Render words: busy until the last column; columns stream one
//   per cycle from the single ring read port.
// Rising trigger adds a ring walk, one entry per cycle; phase trigger adds
//   two divisions unless the block size is zero.
// Synchronous active-low reset; unwritten ring entries read as zero.
// ----------------------------------------------------------------------------
// scope_decimate_trigger_render_core
// Peak decimation of audio samples into a ring, edge or phase triggered
// start search, and rendering of ring entries into saturated screen Y values.
// ----------------------------------------------------------------------------
module scope_decimate_trigger_render_core #(
    parameter int RING_DEPTH  = 2048,
    parameter int MAX_COLUMNS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  sdtr_pkg::t_req_word                 i_req,
    output logic                                busy,
    output logic                                o_res_valid,
    output sdtr_pkg::t_res_word                 o_res,
    input  logic                                i_cfg_we,
    input  sdtr_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [sdtr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW  = $clog2(RING_DEPTH);
    localparam int LW  = $clog2(RING_DEPTH + 1);
    localparam int DW  = 16 + LW;
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int SCW = $clog2(RING_DEPTH + 2);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DIV   = 6'b000100,
        S_LOAD  = 6'b001000,
        S_EMIT  = 6'b010000,
        S_DRAIN = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        D_LEN = 2'b01,
        D_QUO = 2'b10
    } t_dstep;

    // ring step helpers
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        return (a == AW'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        return (a == '0) ? AW'(RING_DEPTH - 1) : a - 1'b1;
    endfunction

    // config registers
    logic [11:0] r_spp;
    logic [15:0] r_zoom;
    logic [1:0]  r_trig;
    logic [6:0]  r_width;
    logic [11:0] r_height;
    logic [15:0] r_phase;
    logic [15:0] r_block;

    // decimation state
    logic [AW-1:0]      r_wptr;
    logic               r_wrapped;
    logic [11:0]        r_left;
    logic signed [15:0] r_run_max;
    logic [AW-1:0]      n_wptr;
    logic [11:0]        n_left;
    logic signed [15:0] n_run_max;
    logic               dump;

    // ring memory and read port
    logic signed [15:0] mem [RING_DEPTH];
    logic signed [15:0] r_rd_raw;
    logic               r_rd_ok;
    logic signed [15:0] rd_val;

    // sequencer
    t_state        r_state;
    t_dstep        r_dstep;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_start;
    logic [CW-1:0] r_w;
    logic [CW-1:0] r_k;
    logic [SCW-1:0] r_cnt;
    logic          r_rd_scan;
    logic [AW-1:0] r_rd_pos;
    logic          r_hold_v;
    logic signed [15:0] r_hold;
    logic [AW-1:0] r_hold_pos;

    // divider hookup
    logic          r_dgo;
    logic [DW-1:0] r_dnum;
    logic [DW-1:0] r_dden;
    logic          div_done;
    logic [DW-1:0] div_quo;

    // y pipeline
    logic               r_p0_v, r_p1_v, r_p2_v;
    logic [CW-1:0]      r_p0_k, r_p1_k, r_p2_k;
    logic               r_p0_last, r_p1_last, r_p2_last;
    logic signed [32:0] r_m;
    logic signed [46:0] r_pr;
    logic signed [33:0] v_lin;
    logic signed [18:0] y_full;
    logic signed [15:0] y_sat;

    logic          accept;
    logic          acc_smp;
    logic          acc_rnd;
    logic [CW-1:0] w_clamp;
    logic [AW-1:0] def_start;
    logic [12:0]   eff_spp;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign acc_smp = accept && (i_req.req_type == sdtr_pkg::REQ_SAMPLE);
    assign acc_rnd = accept && (i_req.req_type == sdtr_pkg::REQ_RENDER);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp    <= sdtr_pkg::RST_SPP;
            r_zoom   <= sdtr_pkg::RST_ZOOM;
            r_trig   <= sdtr_pkg::RST_TRIG;
            r_width  <= sdtr_pkg::RST_WIDTH;
            r_height <= sdtr_pkg::RST_HEIGHT;
            r_phase  <= sdtr_pkg::RST_PHASE;
            r_block  <= sdtr_pkg::RST_BLOCK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdtr_pkg::CFG_SPP:    r_spp    <= i_cfg_data[11:0];
                sdtr_pkg::CFG_ZOOM:   r_zoom   <= i_cfg_data;
                sdtr_pkg::CFG_TRIG:   r_trig   <= i_cfg_data[1:0];
                sdtr_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[6:0];
                sdtr_pkg::CFG_HEIGHT: r_height <= i_cfg_data[11:0];
                sdtr_pkg::CFG_PHASE:  r_phase  <= i_cfg_data;
                sdtr_pkg::CFG_BLOCK:  r_block  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decimation next values
    always_comb begin
        n_run_max = (i_req.sample > r_run_max) ? i_req.sample : r_run_max;
        n_left    = r_left - 12'd1;
        dump      = (n_left == 12'd0);
        n_wptr    = ring_inc(r_wptr);
    end

    // running max and write pointer; no running min is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr    <= '0;
            r_wrapped <= 1'b0;
            r_left    <= sdtr_pkg::RST_SPP;
            r_run_max <= sdtr_pkg::SAMPLE_MIN;
        end else if (acc_smp) begin
            if (dump) begin
                r_run_max <= sdtr_pkg::SAMPLE_MIN;
                r_left    <= r_spp;
                r_wptr    <= n_wptr;
                if (r_wptr == AW'(RING_DEPTH - 1)) begin
                    r_wrapped <= 1'b1;
                end
            end else begin
                r_run_max <= n_run_max;
                r_left    <= n_left;
            end
        end
    end

    // ring memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (acc_smp && dump) begin
            mem[r_wptr] <= n_run_max;
        end
        r_rd_raw <= mem[r_ptr];
    end

    // entries past the fill point have never been written and read as zero
    always_ff @(posedge i_clk) begin
        r_rd_ok <= r_wrapped || (r_ptr < r_wptr);
    end

    assign rd_val = r_rd_ok ? r_rd_raw : 16'sd0;

    // render setup values
    always_comb begin
        if (r_width == 7'd0) begin
            w_clamp = CW'(1);
        end else if (r_width > 7'(MAX_COLUMNS)) begin
            w_clamp = CW'(MAX_COLUMNS);
        end else begin
            w_clamp = CW'(r_width);
        end
        if ({1'b0, r_wptr} >= (AW + 1)'(w_clamp)) begin
            def_start = AW'({1'b0, r_wptr} - (AW + 1)'(w_clamp));
        end else begin
            def_start = AW'({1'b0, r_wptr} + (AW + 1)'(RING_DEPTH) - (AW + 1)'(w_clamp));
        end
        eff_spp = (r_spp == 12'd0) ? 13'd4096 : {1'b0, r_spp};
    end

    // shared divider for the phase trigger
    sdtr_div #(
        .W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_dgo),
        .i_num   (r_dnum),
        .i_den   (r_dden),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // render sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dstep   <= D_LEN;
            r_dgo     <= 1'b0;
            r_rd_scan <= 1'b0;
            r_hold_v  <= 1'b0;
            r_p0_v    <= 1'b0;
            r_cnt     <= '0;
            r_k       <= '0;
        end else begin
            r_dgo     <= 1'b0;
            r_rd_scan <= 1'b0;
            r_p0_v    <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (acc_rnd) begin
                        r_w      <= w_clamp;
                        r_start  <= def_start;
                        r_ptr    <= def_start;
                        r_cnt    <= '0;
                        r_hold_v <= 1'b0;
                        priority if (r_trig == sdtr_pkg::TRIG_RISE) begin
                            r_state <= S_SCAN;
                        end else if (r_trig == sdtr_pkg::TRIG_PHASE) begin
                            if (r_block == 16'd0) begin
                                r_start <= '0;
                                r_state <= S_LOAD;
                            end else begin
                                r_dnum  <= DW'(RING_DEPTH);
                                r_dden  <= DW'(eff_spp);
                                r_dgo   <= 1'b1;
                                r_dstep <= D_LEN;
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                // walk the ring backwards, the last rising crossing met in the walk wins
                S_SCAN: begin
                    if (r_cnt != SCW'(RING_DEPTH + 1)) begin
                        r_ptr     <= ring_dec(r_ptr);
                        r_cnt     <= r_cnt + 1'b1;
                        r_rd_scan <= 1'b1;
                        r_rd_pos  <= r_ptr;
                    end
                    if (r_rd_scan) begin
                        if (r_hold_v && (r_hold > 16'sd0) && (rd_val <= 16'sd0)) begin
                            r_start <= r_hold_pos;
                        end
                        r_hold     <= rd_val;
                        r_hold_pos <= r_rd_pos;
                        r_hold_v   <= 1'b1;
                    end else if (r_cnt == SCW'(RING_DEPTH + 1)) begin
                        r_state <= S_LOAD;
                    end
                end
                // ring length, then phase scaling; the power-of-two ring
                // depth makes the wrap a mask
                S_DIV: begin
                    unique case (r_dstep)
                        D_LEN: begin
                            if (div_done) begin
                                r_dnum  <= DW'(r_phase) * DW'(div_quo[LW-1:0]);
                                r_dden  <= DW'(r_block);
                                r_dgo   <= 1'b1;
                                r_dstep <= D_QUO;
                            end
                        end
                        D_QUO: begin
                            if (div_done) begin
                                r_start <= div_quo[AW-1:0];
                                r_state <= S_LOAD;
                            end
                        end
                        default: r_dstep <= D_LEN;
                    endcase
                end
                S_LOAD: begin
                    r_ptr   <= ring_inc(r_start);
                    r_k     <= '0;
                    r_state <= S_EMIT;
                end
                // one ring read per column
                S_EMIT: begin
                    r_ptr     <= ring_inc(r_ptr);
                    r_k       <= r_k + 1'b1;
                    r_p0_v    <= 1'b1;
                    r_p0_k    <= r_k;
                    r_p0_last <= (r_k == r_w - 1'b1);
                    if (r_k == r_w - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_p2_v && r_p2_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // y math: linear term, height scale, floor and saturate
    always_comb begin
        v_lin  = $signed(34'sd134217728) - $signed({r_m[32], r_m});
        y_full = r_pr[46:28];
        if (y_full > 19'sd32767) begin
            y_sat = sdtr_pkg::Y_MAX;
        end else if (y_full < -19'sd32768) begin
            y_sat = sdtr_pkg::Y_MIN;
        end else begin
            y_sat = y_full[15:0];
        end
    end

    // y pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_p1_v      <= r_p0_v;
            r_p2_v      <= r_p1_v;
            o_res_valid <= r_p2_v;
        end
    end

    // y pipeline data
    always_ff @(posedge i_clk) begin
        r_m           <= $signed({1'b0, r_zoom}) * rd_val;
        r_p1_k        <= r_p0_k;
        r_p1_last     <= r_p0_last;
        r_pr          <= v_lin * $signed({1'b0, r_height});
        r_p2_k        <= r_p1_k;
        r_p2_last     <= r_p1_last;
        o_res.column  <= 6'(r_p2_k);
        o_res.y_coord <= y_sat;
        o_res.last    <= r_p2_last;
    end

endmodule

// ----- hw/rtl/sdtr_div.sv -----
// ----------------------------------------------------------------------------
// sdtr_div
// Restoring unsigned divider, one quotient bit per cycle. A go pulse loads
// dividend and divisor; done pulses when the last quotient bit is in, with
// the quotient, which holds until the next go.
// ----------------------------------------------------------------------------
module sdtr_div #(
    parameter int W = 28
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_go,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_den;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        shifted = {r_rem, r_q[W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
    end

    // one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? diff[W-1:0] : shifted[W-1:0];
                r_q   <= {r_q[W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_q;

endmodule

// ----- hw/rtl/sdtr_chk.sv -----
// ----------------------------------------------------------------------------
// sdtr_chk
// Port-level checks for the scope core: render sequencing, column order and
// sample handling as seen on the top-level pins.
// ----------------------------------------------------------------------------
module sdtr_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input sdtr_pkg::t_req_word i_req,
    input logic                busy,
    input logic                o_res_valid,
    input sdtr_pkg::t_res_word o_res
);

    // a render request makes the core busy
    a_render_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == sdtr_pkg::REQ_RENDER) |=> busy)
        else $error("render word did not raise busy");

    // a sample word is folded in without stalling
    a_sample_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == sdtr_pkg::REQ_SAMPLE) |=> !busy)
        else $error("sample word raised busy");

    // columns stream back to back in order
    a_col_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last |=>
            o_res_valid && (o_res.column == 6'($past(o_res.column) + 6'd1)))
        else $error("column sequence broken");

    // results only come out of a render
    a_res_in_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result word outside a render");

    // busy drops with the final column
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |-> !busy)
        else $error("still busy on final column");

endmodule

bind scope_decimate_trigger_render_core sdtr_chk u_sdtr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .i_req       (i_req),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

// ----- sim/tb_scope_decimate_trigger_render_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scope_decimate_trigger_render_core
// Self-checking bench for the scope core. Sample and render words go in
// through the start/busy handshake with random gaps. An in-bench copy of the
// peak ring, decimation counter and trigger search predicts every screen
// point. Each strobed result word is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_scope_decimate_trigger_render_core;

    localparam int RING_DEPTH   = 2048;
    localparam int MAX_COLUMNS  = 64;
    localparam int RANDOM_WORDS = 340;
    localparam int QUIET_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 16;

    // trigger modes the package leaves unnamed, both run free
    localparam logic [1:0] TRIG_FREE     = 2'd2;
    localparam logic [1:0] TRIG_FREE_ALT = 2'd3;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            start      = 1'b0;
    sdtr_pkg::t_req_word             i_req      = '0;
    logic                            busy;
    logic                            o_res_valid;
    sdtr_pkg::t_res_word             o_res;
    logic                            i_cfg_we   = 1'b0;
    sdtr_pkg::t_cfg_idx              i_cfg_idx  = sdtr_pkg::CFG_SPP;
    logic [sdtr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // register copy
    logic [11:0] cfg_spp    = sdtr_pkg::RST_SPP;
    logic [15:0] cfg_zoom   = sdtr_pkg::RST_ZOOM;
    logic [1:0]  cfg_trig   = sdtr_pkg::RST_TRIG;
    logic [6:0]  cfg_width  = sdtr_pkg::RST_WIDTH;
    logic [11:0] cfg_height = sdtr_pkg::RST_HEIGHT;
    logic [15:0] cfg_phase  = sdtr_pkg::RST_PHASE;
    logic [15:0] cfg_block  = sdtr_pkg::RST_BLOCK;

    // decimation state copy
    logic signed [15:0] peak_hist [RING_DEPTH];
    logic [10:0]        hist_wr   = '0;
    logic [11:0]        fold_left = 12'd64;
    logic signed [15:0] fold_hi   = sdtr_pkg::SAMPLE_MIN;

    sdtr_pkg::t_res_word points_due[$];
    int        fails       = 0;
    int        words_sent  = 0;
    int        quiet_ticks = 0;

    scope_decimate_trigger_render_core #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // screen y of one peak, floor of the scaled value, saturated
    function automatic logic signed [15:0] screen_y(logic signed [15:0] peak);
        longint zl, hl, pl, prod;
        zl = cfg_zoom;
        hl = cfg_height;
        pl = peak;
        prod = ((longint'(1) << 27) - zl * pl) * hl;
        prod = prod >>> 28;
        if (prod > 32767)
            return sdtr_pkg::Y_MAX;
        if (prod < -32768)
            return sdtr_pkg::Y_MIN;
        return prod[15:0];
    endfunction

    // fold one sample into the running max, store a peak when the count ends
    function automatic void fold_sample(logic signed [15:0] s);
        if (s > fold_hi)
            fold_hi = s;
        fold_left = fold_left - 12'd1;
        if (fold_left == '0) begin
            peak_hist[hist_wr] = fold_hi;
            fold_hi = sdtr_pkg::SAMPLE_MIN;
            fold_left = cfg_spp;
            hist_wr = hist_wr + 11'd1;
        end
    endfunction

    // pick the start entry, then queue one screen point per column
    function automatic void render_points();
        int          w;
        int unsigned eff, span;
        logic [10:0] first, t, prev, pos;
        sdtr_pkg::t_res_word pt;
        w = cfg_width;
        if (w == 0)
            w = 1;
        if (w > MAX_COLUMNS)
            w = MAX_COLUMNS;
        first = hist_wr - 11'(w);
        if (cfg_trig == sdtr_pkg::TRIG_RISE) begin
            // walk back over the whole ring, last rising crossing met wins
            t = first;
            for (int n = 0; n < RING_DEPTH; n++) begin
                prev = t - 11'd1;
                if (peak_hist[prev] <= 16'sd0 && peak_hist[t] > 16'sd0)
                    first = t;
                t = prev;
            end
        end else if (cfg_trig == sdtr_pkg::TRIG_PHASE) begin
            if (cfg_block == '0) begin
                first = '0;
            end else begin
                eff = (cfg_spp == '0) ? 4096 : cfg_spp;
                span = RING_DEPTH / eff;
                first = 11'((cfg_phase * span / cfg_block) % RING_DEPTH);
            end
        end
        pos = first;
        for (int k = 0; k < w; k++) begin
            pos = pos + 11'd1;
            pt.column = 6'(k);
            pt.y_coord = screen_y(peak_hist[pos]);
            pt.last = (k == w - 1);
            points_due.push_back(pt);
        end
    endfunction

    // one word through the start/busy handshake; start stays high afterwards
    task automatic send_word(logic rt, logic signed [15:0] s, int gap);
        sdtr_pkg::t_req_word w;
        w.req_type = rt;
        w.sample = s;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= w;
        do @(posedge i_clk); while (busy);
        if (rt == sdtr_pkg::REQ_RENDER)
            render_points();
        else
            fold_sample(s);
        words_sent++;
    endtask

    // stop sending, let every expected point arrive and the core go idle
    task automatic settle();
        start <= 1'b0;
        while (points_due.size() != 0 || busy) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(sdtr_pkg::t_cfg_idx idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sdtr_pkg::CFG_SPP:    cfg_spp = val[11:0];
            sdtr_pkg::CFG_ZOOM:   cfg_zoom = val;
            sdtr_pkg::CFG_TRIG:   cfg_trig = val[1:0];
            sdtr_pkg::CFG_WIDTH:  cfg_width = val[6:0];
            sdtr_pkg::CFG_HEIGHT: cfg_height = val[11:0];
            sdtr_pkg::CFG_PHASE:  cfg_phase = val;
            sdtr_pkg::CFG_BLOCK:  cfg_block = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // render straight out of reset: rising search over an all-zero ring
    task automatic test_reset_render();
        send_word(sdtr_pkg::REQ_RENDER, 16'sd0, 0);
        settle();
    endtask

    // width, height, zoom, samples per pixel, trigger, phase and block corners on an empty ring
    task automatic test_render_settings();
        write_reg(sdtr_pkg::CFG_TRIG, 16'(TRIG_FREE_ALT));
        write_reg(sdtr_pkg::CFG_WIDTH, 16'd0);
        send_word(sdtr_pkg::REQ_RENDER, 16'sh7fff, 0);
        settle();
        write_reg(sdtr_pkg::CFG_WIDTH, 16'd127);
        write_reg(sdtr_pkg::CFG_HEIGHT, 16'd0);
        send_word(sdtr_pkg::REQ_RENDER, 16'sh0000, 3);
        settle();
        // phase mode with zero block size
        write_reg(sdtr_pkg::CFG_HEIGHT, 16'd4095);
        write_reg(sdtr_pkg::CFG_ZOOM, 16'd0);
        write_reg(sdtr_pkg::CFG_WIDTH, 16'd1);
        write_reg(sdtr_pkg::CFG_TRIG, 16'(sdtr_pkg::TRIG_PHASE));
        write_reg(sdtr_pkg::CFG_BLOCK, 16'd0);
        send_word(sdtr_pkg::REQ_RENDER, 16'sh8000, 0);
        settle();
        // zero samples per pixel gives an empty ring length
        write_reg(sdtr_pkg::CFG_SPP, 16'd0);
        write_reg(sdtr_pkg::CFG_BLOCK, 16'hffff);
        write_reg(sdtr_pkg::CFG_PHASE, 16'hffff);
        send_word(sdtr_pkg::REQ_RENDER, 16'sh5555, 1);
        settle();
        write_reg(sdtr_pkg::CFG_SPP, 16'd1);
        write_reg(sdtr_pkg::CFG_BLOCK, 16'd3);
        send_word(sdtr_pkg::REQ_RENDER, 16'shaaaa, 0);
        settle();
        write_reg(sdtr_pkg::CFG_ZOOM, 16'hffff);
        write_reg(sdtr_pkg::CFG_TRIG, 16'(sdtr_pkg::TRIG_RISE));
        write_reg(sdtr_pkg::CFG_WIDTH, 16'd64);
        send_word(sdtr_pkg::REQ_RENDER, 16'shffff, 0);
        settle();
    endtask

    // extreme sample values while the reset count is still running
    task automatic test_sample_extremes();
        logic [15:0] corner_vals [14] = '{
            16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h5555, 16'haaaa,
            16'h7ffe, 16'h8001, 16'h00ff, 16'hff00, 16'h4000, 16'hc000, 16'h0000
        };
        write_reg(sdtr_pkg::CFG_TRIG, 16'(TRIG_FREE));
        for (int i = 0; i < 14; i++)
            send_word(sdtr_pkg::REQ_SAMPLE, corner_vals[i],
                      (i < 7) ? 0 : $urandom_range(0, 12));
        send_word(sdtr_pkg::REQ_RENDER, 16'hffff, 0);
        send_word(sdtr_pkg::REQ_RENDER, 16'h0000, 0);
        settle();
    endtask

    // random phases: new settings, then a burst of samples and renders
    task automatic test_random_traffic();
        int          target, burst, gap_mode, shape, gap, sel;
        logic        wide_spp, rt;
        logic [15:0] val;
        logic signed [15:0] s;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            settle();
            wide_spp = ($urandom_range(0, 5) == 0);
            if (wide_spp) begin
                case ($urandom_range(0, 3))
                    0: val = 16'd0;
                    1: val = 16'd2048;
                    2: val = 16'd4095;
                    default: val = 16'($urandom_range(0, 4095));
                endcase
            end else begin
                val = 16'($urandom_range(1, 4));
            end
            write_reg(sdtr_pkg::CFG_SPP, val);
            case ($urandom_range(0, 3))
                0: val = 16'd0;
                1: val = 16'hffff;
                2: val = 16'd4096;
                default: val = 16'($urandom);
            endcase
            write_reg(sdtr_pkg::CFG_ZOOM, val);
            write_reg(sdtr_pkg::CFG_TRIG, 16'($urandom_range(0, 3)));
            case ($urandom_range(0, 4))
                0: val = 16'd0;
                1: val = 16'd1;
                2: val = 16'd64;
                3: val = 16'd127;
                default: val = 16'($urandom_range(0, 127));
            endcase
            write_reg(sdtr_pkg::CFG_WIDTH, val);
            case ($urandom_range(0, 3))
                0: val = 16'd0;
                1: val = 16'd1;
                2: val = 16'd4095;
                default: val = 16'($urandom_range(0, 4095));
            endcase
            write_reg(sdtr_pkg::CFG_HEIGHT, val);
            case ($urandom_range(0, 3))
                0: val = 16'd0;
                1: val = 16'hffff;
                default: val = 16'($urandom);
            endcase
            write_reg(sdtr_pkg::CFG_PHASE, val);
            case ($urandom_range(0, 4))
                0: val = 16'd0;
                1: val = 16'd1;
                2: val = 16'hffff;
                default: val = 16'($urandom);
            endcase
            write_reg(sdtr_pkg::CFG_BLOCK, val);

            gap_mode = $urandom_range(0, 2);
            shape = $urandom_range(0, 2);
            // with a wide count setting only render words go in, so the ring stays as it is
            burst = wide_spp ? 2 : $urandom_range(20, 45);
            for (int i = 0; i < burst; i++) begin
                case (gap_mode)
                    0: gap = 0;
                    1: gap = $urandom_range(0, 12);
                    default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
                endcase
                rt = wide_spp || (i == burst - 1) || ($urandom_range(0, 14) == 0);
                case (shape)
                    // small swings around zero give many rising crossings
                    1: s = 16'(int'($urandom_range(0, 4000)) - 2000);
                    2: begin
                        sel = $urandom_range(0, 4);
                        case (sel)
                            0: s = 16'sh7fff;
                            1: s = 16'sh8000;
                            2: s = 16'sh0000;
                            3: s = 16'sh0001;
                            default: s = 16'shffff;
                        endcase
                    end
                    default: s = 16'($urandom);
                endcase
                send_word(rt, s, gap);
            end
        end
    endtask

    // compare every strobed result word against the oldest expected point
    always @(posedge i_clk) begin : check_points
        sdtr_pkg::t_res_word want;
        if (i_rst_n && o_res_valid) begin
            if (points_due.size() == 0) begin
                $error("unexpected result word: column %0d y_coord %0d last %0b",
                       o_res.column, o_res.y_coord, o_res.last);
                fails++;
            end else begin
                want = points_due.pop_front();
                if (o_res.column !== want.column) begin
                    $error("column: expected %0d, got %0d", want.column, o_res.column);
                    fails++;
                end
                if (o_res.y_coord !== want.y_coord) begin
                    $error("y_coord: expected %0d, got %0d", want.y_coord, o_res.y_coord);
                    fails++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_res.last);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_res_valid || i_cfg_we)
            quiet_ticks = 0;
        else
            quiet_ticks++;
        if (quiet_ticks >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        foreach (peak_hist[i])
            peak_hist[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_render();
        test_render_settings();
        test_sample_extremes();
        test_random_traffic();
        settle();

        if (points_due.size() != 0) begin
            $error("%0d screen points never arrived", points_due.size());
            fails++;
        end
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/sdtr_pkg.sv
hw/rtl/sdtr_div.sv
hw/rtl/scope_decimate_trigger_render_core.sv
hw/rtl/sdtr_chk.sv
sim/tb_scope_decimate_trigger_render_core.sv
